/* sv/rolling_adler32_window_core_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the rolling Adler-32 window core
// Implication checks that compile away when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef ROLLING_ADLER32_WINDOW_CORE_ASSERT_SVH
`define ROLLING_ADLER32_WINDOW_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
// Same-cycle implication
`define AD32W_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rolling_adler32_window_core: same-cycle check failed");
// Next-cycle implication
`define AD32W_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rolling_adler32_window_core: next-cycle check failed");
`else
`define AD32W_ASSERT_IMP(label, clk, rst, ante, cons)
`define AD32W_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* sv/ad32w_pkg.sv */
// ----------------------------------------------------------------------------
// ad32w_pkg
// Shared constants and types of the rolling Adler-32 window core.
// ----------------------------------------------------------------------------
`default_nettype none

package ad32w_pkg;

   localparam int CSR_W          = 13;
   localparam int BYTE_W         = 8;
   localparam int SUM_W          = 16;
   localparam int CHECKSUM_W     = 32;
   localparam int MAX_WINDOW_DEF = 4096;
   localparam int RSP_DEPTH      = 8;

   // Adler modulus and 2^16 folded back under it
   localparam logic [SUM_W-1:0] ADLER_MOD  = 16'd65521;
   localparam logic [3:0]       ADLER_FOLD = 4'd15;

   // Item tag that travels alongside the term pipeline
   typedef struct packed {
      logic              valid;
      logic              start;
      logic              sub;
      logic              wfull;
      logic [BYTE_W-1:0] data_byte;
   } ad32w_tag_type;

   // Finished result waiting in the output queue
   typedef struct packed {
      logic [CHECKSUM_W-1:0] checksum;
      logic                  window_full;
   } ad32w_rsp_type;

endpackage

`default_nettype wire

/* sv/ad32w_store.sv */
// ----------------------------------------------------------------------------
// ad32w_store
// Window byte store: one address port, read-first, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ad32w_store import ad32w_pkg::*; #(
   parameter int DEPTH  = MAX_WINDOW_DEF,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              write_en,
   input  wire logic              read_en,
   input  wire logic [ADDR_W-1:0] addr,
   input  wire logic [BYTE_W-1:0] write_data,
   output      logic [BYTE_W-1:0] read_data
);

   logic [BYTE_W-1:0] mem [DEPTH];
   logic [BYTE_W-1:0] read_data_ff;

   // Read the old byte and overwrite it on the same edge
   always_ff @(posedge clock) begin
      if (read_en) begin
         read_data_ff <= mem[addr];
      end
      if (write_en) begin
         mem[addr] <= write_data;
      end
   end

   assign read_data = read_data_ff;

endmodule

`default_nettype wire

/* sv/ad32w_term.sv */
// ----------------------------------------------------------------------------
// ad32w_term
// Two-stage unit for the leaving byte's B term: (1 + n*old) mod 65521.
// ----------------------------------------------------------------------------
`default_nettype none

module ad32w_term import ad32w_pkg::*; #(
   parameter int NW = 13
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire ad32w_tag_type     tag_in,
   input  wire logic [NW-1:0]     win_len,
   input  wire logic [BYTE_W-1:0] read_data,
   output      ad32w_tag_type     tag_out,
   output      logic [BYTE_W-1:0] old_out,
   output      logic [SUM_W-1:0]  term_out
);

   localparam int PW = (NW + BYTE_W + 1 > SUM_W + 1) ? NW + BYTE_W + 1 : SUM_W + 1;
   localparam int HW = PW - SUM_W;
   localparam int FW = SUM_W + 2;

   ad32w_tag_type     tag_a_ff, tag_b_ff;
   logic [BYTE_W-1:0] old_a_ff, old_b_ff;
   logic [PW-1:0]     prod_a_ff;
   logic [SUM_W-1:0]  term_b_ff;

   logic [BYTE_W-1:0] old_a_in;
   logic [PW-1:0]     prod_a_in;
   logic [HW-1:0]     prod_hi;
   logic [FW-1:0]     fold;
   logic [SUM_W-1:0]  term_b_in;

   // Multiply: old byte only counts when the window is full
   always_comb begin
      old_a_in  = tag_in.sub ? read_data : '0;
      prod_a_in = PW'(win_len) * PW'(old_a_in) + PW'(tag_in.sub);
   end

   // Reduce: fold the upper part by 2^16 = 15, then one subtract
   always_comb begin
      prod_hi   = prod_a_ff[PW-1:SUM_W];
      fold      = FW'(prod_a_ff[SUM_W-1:0]) + FW'(prod_hi) * FW'(ADLER_FOLD);
      term_b_in = (fold >= FW'(ADLER_MOD)) ? SUM_W'(fold - FW'(ADLER_MOD))
                                           : SUM_W'(fold);
   end

   // Advance both stages every cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         tag_a_ff <= '0;
         tag_b_ff <= '0;
      end else begin
         tag_a_ff <= tag_in;
         tag_b_ff <= tag_a_ff;
      end
      old_a_ff  <= old_a_in;
      prod_a_ff <= prod_a_in;
      old_b_ff  <= old_a_ff;
      term_b_ff <= term_b_in;
   end

   assign tag_out  = tag_b_ff;
   assign old_out  = old_b_ff;
   assign term_out = term_b_ff;

endmodule

`default_nettype wire

/* sv/ad32w_fifo.sv */
// ----------------------------------------------------------------------------
// ad32w_fifo
// Small result queue that decouples the pipeline from the result stall.
// ----------------------------------------------------------------------------
`default_nettype none

module ad32w_fifo import ad32w_pkg::*; #(
   parameter int DEPTH = RSP_DEPTH
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push,
   input  wire ad32w_rsp_type push_data,
   input  wire logic          pop,
   output      logic          out_valid,
   output      ad32w_rsp_type out_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   ad32w_rsp_type    mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;

   // Store the pushed item
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   // Advance pointers and occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         count_ff <= count_ff + CNT_W'(push) - CNT_W'(pop);
      end
   end

   assign out_valid = (count_ff != '0);
   assign out_data  = mem_ff[rd_ptr_ff];

endmodule

`default_nettype wire

/* sv/rolling_adler32_window_core.sv */
// ----------------------------------------------------------------------------
// rolling_adler32_window_core
// Rolling Adler-32 over the last window_size bytes of a byte stream.
// ----------------------------------------------------------------------------
// Takes one byte per clock and returns, for every byte, the Adler-32 checksum
// (B in the upper half, A in the lower half) of the last window_size bytes;
// window_size 0 gives the plain running checksum since the last start. A result
// is offered once its byte has passed the window store's read-first port,
// the (1 + n*old) mod 65521 unit and the A/B update, which is the only loop
// that carries from byte to byte. An eight-entry result queue lets bytes keep
// flowing while results are stalled; input stalls only once eight items are
// in flight. Writing window_size restarts the checksum; sizes above
// MAX_WINDOW act as MAX_WINDOW.
`default_nettype none

module rolling_adler32_window_core import ad32w_pkg::*; #(
   parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_write_enable,
   input  wire logic [CSR_W-1:0]      csr_write_data,
   input  wire logic                  req_valid,
   output      logic                  req_stall,
   input  wire logic [BYTE_W-1:0]     req_data_byte,
   input  wire logic                  req_start_new,
   output      logic                  rsp_valid,
   input  wire logic                  rsp_stall,
   output      logic [CHECKSUM_W-1:0] rsp_checksum,
   output      logic                  rsp_window_full
);

`include "rolling_adler32_window_core_assert.svh"

   localparam int NW    = $clog2(MAX_WINDOW + 1);
   localparam int AW    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int CMP_W = (NW > CSR_W) ? NW : CSR_W;
   localparam int CNT_W = $clog2(RSP_DEPTH + 1);
   localparam int ACC_W = SUM_W + 2;

   logic [CSR_W-1:0] win_size_ff;
   logic [AW-1:0]    wp_ff, wp_in;
   logic [NW-1:0]    fill_ff, fill_in;
   logic [SUM_W-1:0] sum_a_ff, sum_a_in, sum_b_ff, sum_b_in;
   logic [CNT_W-1:0] out_cnt_ff;
   ad32w_tag_type    tag_s1_ff, tag_s1_in;

   logic          accept, deliver;
   logic [NW-1:0] win_len, fill_base, fill_next, ptr_inc;
   logic [AW-1:0] ptr_base, ptr_cur, ptr_next;
   logic          win_on, sub;

   logic [BYTE_W-1:0] rd_data, old_t;
   logic [SUM_W-1:0]  term_t, a_base, b_base;
   logic [ACC_W-1:0]  a_acc, b_acc;
   ad32w_tag_type     tag_t;
   ad32w_rsp_type     rsp_push, rsp_data;

   assign accept    = req_valid && !req_stall;
   assign deliver   = rsp_valid && !rsp_stall;
   assign req_stall = (out_cnt_ff == CNT_W'(RSP_DEPTH));

   // Clamp the window length
   always_comb begin
      win_len = (CMP_W'(win_size_ff) > CMP_W'(MAX_WINDOW)) ? NW'(MAX_WINDOW)
                                                          : NW'(win_size_ff);
      win_on  = (win_len != '0);
   end

   // Pointer and fill bookkeeping for the item at the input
   always_comb begin
      ptr_base  = req_start_new ? '0 : wp_ff;
      fill_base = req_start_new ? '0 : fill_ff;
      ptr_cur   = (NW'(ptr_base) >= win_len) ? '0 : ptr_base;
      sub       = win_on && (fill_base >= win_len);
      fill_next = sub ? win_len : fill_base + 1'b1;
      ptr_inc   = NW'(ptr_cur) + 1'b1;
      ptr_next  = (ptr_inc >= win_len) ? '0 : AW'(ptr_inc);
      wp_in     = win_on ? ptr_next : ptr_base;
      fill_in   = win_on ? fill_next : fill_base;

      tag_s1_in.valid     = 1'b1;
      tag_s1_in.start     = req_start_new;
      tag_s1_in.sub       = sub;
      tag_s1_in.wfull     = win_on && (fill_next == win_len);
      tag_s1_in.data_byte = req_data_byte;
   end

   // Hold configuration and input-side state
   always_ff @(posedge clock) begin
      if (reset) begin
         win_size_ff <= '0;
         wp_ff       <= '0;
         fill_ff     <= '0;
         tag_s1_ff   <= '0;
      end else begin
         if (csr_write_enable) begin
            win_size_ff <= csr_write_data;
            wp_ff       <= '0;
            fill_ff     <= '0;
         end else if (accept) begin
            wp_ff   <= wp_in;
            fill_ff <= fill_in;
         end
         if (accept) begin
            tag_s1_ff <= tag_s1_in;
         end else begin
            tag_s1_ff.valid <= 1'b0;
         end
      end
   end

   // Count items taken but not yet delivered
   always_ff @(posedge clock) begin
      if (reset) begin
         out_cnt_ff <= '0;
      end else begin
         out_cnt_ff <= out_cnt_ff + CNT_W'(accept) - CNT_W'(deliver);
      end
   end

   ad32w_store #(
      .DEPTH  (MAX_WINDOW),
      .ADDR_W (AW)
   ) u_store (
      .clock      (clock),
      .write_en   (accept && win_on),
      .read_en    (accept && sub),
      .addr       (ptr_cur),
      .write_data (req_data_byte),
      .read_data  (rd_data)
   );

   ad32w_term #(
      .NW (NW)
   ) u_term (
      .clock     (clock),
      .reset     (reset),
      .tag_in    (tag_s1_ff),
      .win_len   (win_len),
      .read_data (rd_data),
      .tag_out   (tag_t),
      .old_out   (old_t),
      .term_out  (term_t)
   );

   // Update A and B: drop the leaving byte, add the new one
   always_comb begin
      a_base = tag_t.start ? SUM_W'(1) : sum_a_ff;
      b_base = tag_t.start ? '0 : sum_b_ff;

      a_acc = ACC_W'(a_base) + ACC_W'(tag_t.data_byte) - ACC_W'(old_t);
      if (a_acc[ACC_W-1]) begin
         sum_a_in = SUM_W'(a_acc + ACC_W'(ADLER_MOD));
      end else if (a_acc >= ACC_W'(ADLER_MOD)) begin
         sum_a_in = SUM_W'(a_acc - ACC_W'(ADLER_MOD));
      end else begin
         sum_a_in = SUM_W'(a_acc);
      end

      b_acc = ACC_W'(b_base) - ACC_W'(term_t) + ACC_W'(sum_a_in);
      if (b_acc[ACC_W-1]) begin
         sum_b_in = SUM_W'(b_acc + ACC_W'(ADLER_MOD));
      end else if (b_acc >= ACC_W'(ADLER_MOD)) begin
         sum_b_in = SUM_W'(b_acc - ACC_W'(ADLER_MOD));
      end else begin
         sum_b_in = SUM_W'(b_acc);
      end

      rsp_push.checksum    = {sum_b_in, sum_a_in};
      rsp_push.window_full = tag_t.wfull;
   end

   // Hold the running sums
   always_ff @(posedge clock) begin
      if (reset) begin
         sum_a_ff <= SUM_W'(1);
         sum_b_ff <= '0;
      end else if (csr_write_enable) begin
         sum_a_ff <= SUM_W'(1);
         sum_b_ff <= '0;
      end else if (tag_t.valid) begin
         sum_a_ff <= sum_a_in;
         sum_b_ff <= sum_b_in;
      end
   end

   ad32w_fifo #(
      .DEPTH (RSP_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (tag_t.valid),
      .push_data (rsp_push),
      .pop       (deliver),
      .out_valid (rsp_valid),
      .out_data  (rsp_data)
   );

   assign rsp_checksum    = rsp_data.checksum;
   assign rsp_window_full = rsp_data.window_full;

   // Checks
   `AD32W_ASSERT_IMP(a_cnt_bound, clock, reset, 1'b1, out_cnt_ff <= CNT_W'(RSP_DEPTH))
   `AD32W_ASSERT_IMP(a_rsp_owed, clock, reset, rsp_valid, out_cnt_ff != '0)
   `AD32W_ASSERT_IMP(a_sums_reduced, clock, reset, 1'b1, (sum_a_ff < ADLER_MOD) && (sum_b_ff < ADLER_MOD))
   `AD32W_ASSERT_IMP(a_ptr_in_window, clock, reset, win_on, (NW'(wp_ff) < win_len) && (fill_ff <= win_len))
   `AD32W_ASSERT_NEXT(a_accept_tracked, clock, reset, accept, tag_s1_ff.valid)

endmodule

`default_nettype wire
